// ===== hw/rtl/isolated_pixel_counter_macros.svh =====
// Assertion macros for the isolated pixel counter.
// Used by the top-level RTL file, which carries concurrent checks; no other dependencies.
`ifndef ISOLATED_PIXEL_COUNTER_MACROS_SVH
`define ISOLATED_PIXEL_COUNTER_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define IPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define IPC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `IPC_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== hw/rtl/ipc_pkg.sv =====
// Shared types, constants and helpers for the isolated pixel counter.
// No dependencies; imported by every module of the block.
`default_nettype none

package ipc_pkg;

  localparam int unsigned MaxCols   = 1024;
  localparam int unsigned MaxRows   = 1024;
  localparam int unsigned ColW      = $clog2(MaxCols);
  localparam int unsigned RowW      = $clog2(MaxRows);
  localparam int unsigned CfgW      = 11;
  localparam int unsigned CoordW    = 10;
  localparam int unsigned CountW    = 20;
  localparam int unsigned OutDepth  = 3;
  localparam int unsigned PtrW      = $clog2(OutDepth);
  localparam int unsigned LvlW      = $clog2(OutDepth + 1);

  localparam logic [CfgW-1:0]   ColsReset = CfgW'(12);
  localparam logic [CfgW-1:0]   RowsReset = CfgW'(12);
  localparam logic [CfgW-1:0]   SizeMin   = CfgW'(3);
  localparam logic [CountW-1:0] CountMax  = {CountW{1'b1}};

  // configuration register indexes
  typedef enum logic [0:0] {
    RegFrameCols = 1'b0,
    RegFrameRows = 1'b1
  } cfg_reg_e;

  // one window column: [0] row r-2, [1] row r-1, [2] current row
  typedef logic [2:0] win_col_t;

  // write side of the line stores
  typedef struct packed {
    logic            en;
    logic [ColW-1:0] addr;
    logic            upper;
    logic            lower;
  } ls_wr_t;

  // one result transaction
  typedef struct packed {
    logic              center_valid;
    logic              isolated;
    logic [CoordW-1:0] center_row;
    logic [CoordW-1:0] center_col;
    logic [CountW-1:0] island_count;
    logic              frame_done;
  } result_t;

  function automatic logic [CfgW-1:0] clamp_size(logic [CfgW-1:0] v, logic [CfgW-1:0] hi);
    logic [CfgW-1:0] r;
    if (v < SizeMin) begin
      r = SizeMin;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ipc_win_cell.sv =====
// One column cell of the 3x3 window chain; loads its neighbor's column on each step.
// Depends on ipc_pkg.
`default_nettype none

module ipc_win_cell
  import ipc_pkg::*;
(
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      en_i,
  input  win_col_t col_i,
  output win_col_t col_o
);

  win_col_t col_q, col_d;

  always_comb begin
    col_d = en_i ? col_i : col_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ipc_line_store.sv =====
// Pair of one-bit line stores (rows r-2 and r-1) in one memory, registered read.
// Entries past the fill mark read as zero. Depends on ipc_pkg.
`default_nettype none

module ipc_line_store
  import ipc_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire [ColW-1:0]  rd_addr_i,
  input  ls_wr_t          wr_i,
  output logic            upper_o,
  output logic            lower_o
);

  logic [1:0]    mem_q [MaxCols];
  logic [1:0]    rd_q;
  logic          hit_q;
  logic [ColW:0] fill_q, fill_d;

  // written columns always form a prefix, since every row starts at column zero
  always_comb begin
    fill_d = fill_q;
    if (wr_i.en && ({1'b0, wr_i.addr} >= fill_q)) begin
      fill_d = {1'b0, wr_i.addr} + (ColW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= {wr_i.upper, wr_i.lower};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q  <= mem_q[rd_addr_i];
    hit_q <= ({1'b0, rd_addr_i} < fill_q);
  end

  assign upper_o = hit_q & rd_q[1];
  assign lower_o = hit_q & rd_q[0];

endmodule

`default_nettype wire

// ===== hw/rtl/ipc_out_fifo.sv =====
// Small result queue between the window stage and the output channel.
// Depends on ipc_pkg.
`default_nettype none

module ipc_out_fifo
  import ipc_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  result_t         data_i,
  input  wire             pop_i,
  output logic            valid_o,
  output result_t         data_o,
  output logic [LvlW-1:0] level_o
);

  result_t         buf_q [OutDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0] level_q, level_d;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    if (p == PtrW'(OutDepth - 1)) begin
      n = '0;
    end else begin
      n = p + PtrW'(1);
    end
    return n;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    level_d  = level_q;
    if (push_i && !pop_i) begin
      level_d = level_q + LvlW'(1);
    end else if (pop_i && !push_i) begin
      level_d = level_q - LvlW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (level_q != '0);
  assign data_o  = buf_q[rd_ptr_q];
  assign level_o = level_q;

endmodule

`default_nettype wire

// ===== hw/rtl/isolated_pixel_counter.sv =====
// Top level of the isolated pixel counter: position counters, line stores,
// window cell chain and result queue. Depends on ipc_pkg and the ipc_* modules.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   pixel_i
//   out      source     out_valid_o / out_stall_i center_valid_o .. frame_done_o
//   cfg      sink       cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// One pixel per cycle while the result queue has room; the line store is read as a
// pixel is taken, then the window stage register updates the window and pushes the
// result into the queue, from which it can be taken. Reset needs no clearing pass: a
// fill mark stands in. The input stalls only when the three-entry result queue is
// full, counting the transaction in flight.
`default_nettype none

module isolated_pixel_counter
  import ipc_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire                cfg_index_i,
  input  wire [CfgW-1:0]     cfg_wdata_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire                pixel_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic               center_valid_o,
  output logic               isolated_o,
  output logic [CoordW-1:0]  center_row_o,
  output logic [CoordW-1:0]  center_col_o,
  output logic [CountW-1:0]  island_count_o,
  output logic               frame_done_o
);

  `include "isolated_pixel_counter_macros.svh"

  logic [CfgW-1:0]   cols_q, cols_d, rows_q, rows_d;
  logic [CfgW-1:0]   cols_eff, rows_eff;
  logic [ColW-1:0]   col_last;
  logic [RowW-1:0]   row_last;
  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic              in_acc;
  logic              pix_in, center_in, last_in;

  // window stage (registered at acceptance)
  logic              a_q;
  logic              a_pix_q, a_center_q, a_last_q;
  logic [ColW-1:0]   a_col_q;
  logic [RowW-1:0]   a_row_q;

  logic              ls_upper, ls_lower;
  ls_wr_t            ls_wr;
  win_col_t          new_col, hi_col, lo_col;
  logic              lo_any;
  logic              iso;
  logic [CountW-1:0] count_q, count_d, count_now;

  result_t           res;
  result_t           out_res;
  logic              pop;
  logic [LvlW-1:0]   level;
  logic [LvlW:0]     reserved;

  assign cols_eff = clamp_size(cols_q, CfgW'(MaxCols));
  assign rows_eff = clamp_size(rows_q, CfgW'(MaxRows));
  assign col_last = ColW'(cols_eff - CfgW'(1));
  assign row_last = RowW'(rows_eff - CfgW'(1));

  assign reserved   = {1'b0, level} + (LvlW+1)'(a_q);
  assign in_stall_o = (reserved >= (LvlW+1)'(OutDepth));
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    pix_in    = pixel_i & ~((row_q == '0) | (row_q == row_last) |
                            (col_q == '0) | (col_q == col_last));
    center_in = (row_q >= RowW'(2)) & (col_q >= ColW'(2));
    last_in   = (row_q == row_last) & (col_q == col_last);
  end

  // config and position
  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    col_d  = col_q;
    row_d  = row_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegFrameCols: cols_d = cfg_wdata_i;
        RegFrameRows: rows_d = cfg_wdata_i;
        default: ;
      endcase
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (last_in) begin
        col_d = '0;
        row_d = '0;
      end else if (col_q == col_last) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= ColsReset;
      rows_q  <= RowsReset;
      col_q   <= '0;
      row_q   <= '0;
      a_q     <= 1'b0;
      count_q <= '0;
    end else begin
      cols_q  <= cols_d;
      rows_q  <= rows_d;
      col_q   <= col_d;
      row_q   <= row_d;
      a_q     <= in_acc;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_pix_q    <= pix_in;
      a_center_q <= center_in;
      a_last_q   <= last_in;
      a_col_q    <= col_q;
      a_row_q    <= row_q;
    end
  end

  ipc_line_store u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (col_q),
    .wr_i      (ls_wr),
    .upper_o   (ls_upper),
    .lower_o   (ls_lower)
  );

  always_comb begin
    ls_wr.en    = a_q;
    ls_wr.addr  = a_col_q;
    ls_wr.upper = ls_lower;
    ls_wr.lower = a_pix_q;
  end

  assign new_col = {a_pix_q, ls_lower, ls_upper};

  // window columns: new_col is the newest, hi the middle, lo the oldest kept
  ipc_win_cell u_cell_hi (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (a_q),
    .col_i  (new_col),
    .col_o  (hi_col)
  );

  ipc_win_cell u_cell_lo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (a_q),
    .col_i  (hi_col),
    .col_o  (lo_col)
  );

  assign lo_any = |lo_col;

  // center is the middle bit of hi_col, the middle column of the window
  assign iso = a_center_q & hi_col[1] & ~hi_col[0] & ~hi_col[2] & ~lo_any &
               (new_col == '0);

  always_comb begin
    count_now = count_q;
    if (iso && (count_q != CountMax)) begin
      count_now = count_q + CountW'(1);
    end
    count_d = count_q;
    if (cfg_we_i) begin
      count_d = '0;
    end else if (a_q) begin
      count_d = a_last_q ? '0 : count_now;
    end
  end

  always_comb begin
    res.center_valid = a_center_q;
    res.isolated     = iso;
    res.center_row   = a_center_q ? CoordW'(a_row_q - RowW'(1)) : '0;
    res.center_col   = a_center_q ? CoordW'(a_col_q - ColW'(1)) : '0;
    res.island_count = count_now;
    res.frame_done   = a_last_q;
  end

  assign pop = out_valid_o & ~out_stall_i;

  ipc_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (a_q),
    .data_i  (res),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .data_o  (out_res),
    .level_o (level)
  );

  assign center_valid_o = out_res.center_valid;
  assign isolated_o     = out_res.isolated;
  assign center_row_o   = out_res.center_row;
  assign center_col_o   = out_res.center_col;
  assign island_count_o = out_res.island_count;
  assign frame_done_o   = out_res.frame_done;

  `IPC_ASSERT(a_stage_fills, clk_i, rst_ni, in_acc |=> a_q, "accepted pixel missed window stage")
  `IPC_ASSERT_NEVER(queue_overrun, clk_i, rst_ni, a_q && (level == LvlW'(OutDepth)) && !pop,
    "result queue overrun")
  `IPC_ASSERT_NEVER(iso_without_center, clk_i, rst_ni, a_q && iso && !a_center_q,
    "isolated flag outside interior center")
  `IPC_ASSERT(count_cleared_after_done, clk_i, rst_ni, (a_q && a_last_q) |=> (count_q == '0),
    "count not cleared after frame end")

endmodule

`default_nettype wire

// ===== tb/island_ledger_pkg.sv =====
// Scoreboard for the isolated pixel counter: a pixel-accurate model of the
// line stores, 3x3 window and frame counters, plus the queue of predicted results.
// Depends on ipc_pkg for register codes, widths and the result layout.
package island_ledger_pkg;
  import ipc_pkg::*;

  class island_ledger;
    logic [CfgW-1:0]   cols_reg;
    logic [CfgW-1:0]   rows_reg;
    bit                upper_row [MaxCols];
    bit                lower_row [MaxCols];
    bit [8:0]          win;
    int unsigned       row_pos;
    int unsigned       col_pos;
    logic [CountW-1:0] count;
    result_t           predicted_results [$];
    int unsigned       errors;

    function new();
      cols_reg = ColsReset;
      rows_reg = RowsReset;
      foreach (upper_row[i]) begin
        upper_row[i] = 1'b0;
        lower_row[i] = 1'b0;
      end
      win    = '0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      row_pos = 0;
      col_pos = 0;
      count   = '0;
    endfunction

    // size registers are used clamped to [3, hi]
    function int unsigned bounded(logic [CfgW-1:0] v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgW-1:0] val);
      case (idx)
        RegFrameCols: cols_reg = val;
        RegFrameRows: rows_reg = val;
        default: ;
      endcase
      restart();
    endfunction

    function int unsigned pending();
      return predicted_results.size();
    endfunction

    // advance the model by one accepted pixel and queue the result it produces
    function void scan_pixel(bit pixel);
      int unsigned ncols;
      int unsigned nrows;
      int unsigned r;
      int unsigned c;
      bit          up;
      bit          lo;
      bit          land;
      bit          hit;
      result_t     want;
      ncols = bounded(cols_reg, MaxCols);
      nrows = bounded(rows_reg, MaxRows);
      r = (row_pos >= nrows) ? nrows - 1 : row_pos;
      c = (col_pos >= ncols) ? ncols - 1 : col_pos;
      land = pixel;
      if (r == 0 || r == nrows - 1 || c == 0 || c == ncols - 1) land = 1'b0;
      up = upper_row[c];
      lo = lower_row[c];
      // each window row shifts toward column 0, new column enters at column 2
      win = {land, win[8:7], lo, win[5:4], up, win[2:1]};
      upper_row[c] = lo;
      lower_row[c] = land;
      want = '0;
      want.center_valid = (r >= 2) && (c >= 2);
      if (want.center_valid) begin
        hit = win[4] && ((win & 9'h1EF) == 9'h000);
        want.isolated   = hit;
        want.center_row = CoordW'(r - 1);
        want.center_col = CoordW'(c - 1);
        if (hit && count != CountMax) count = count + 1'b1;
      end
      want.island_count = count;
      want.frame_done   = (r == nrows - 1) && (c == ncols - 1);
      if (want.frame_done) begin
        restart();
      end else if (c + 1 >= ncols) begin
        col_pos = 0;
        row_pos = r + 1;
      end else begin
        col_pos = c + 1;
        row_pos = r;
      end
      predicted_results.push_back(want);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (predicted_results.size() == 0) begin
        $error("result transaction with no pixel outstanding: %p", got);
        errors++;
        return;
      end
      want = predicted_results.pop_front();
      compare("center_valid", want.center_valid, got.center_valid);
      compare("isolated", want.isolated, got.isolated);
      compare("center_row", want.center_row, got.center_row);
      compare("center_col", want.center_col, got.center_col);
      compare("island_count", want.island_count, got.island_count);
      compare("frame_done", want.frame_done, got.frame_done);
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
// Testbench top for the isolated pixel counter: drives pixel frames of many
// sizes with random idling and back-pressure, checks every result in order.
// Depends on ipc_pkg, island_ledger_pkg and the isolated_pixel_counter RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ipc_pkg::*;
  import island_ledger_pkg::*;

  localparam int QuietLimit  = 2000;
  localparam int HoldStretch = 300;
  localparam int RandomItems = 660;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_index_i = RegFrameCols;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               pixel_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               center_valid_o;
  logic               isolated_o;
  logic [CoordW-1:0]  center_row_o;
  logic [CoordW-1:0]  center_col_o;
  logic [CountW-1:0]  island_count_o;
  logic               frame_done_o;

  island_ledger ledger;
  int in_idle_pct  = 32;
  int out_idle_pct = 32;
  int hold_left    = 0;

  isolated_pixel_counter dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .pixel_i,
    .out_valid_o, .out_stall_i,
    .center_valid_o, .isolated_o, .center_row_o, .center_col_o,
    .island_count_o, .frame_done_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = (out_idle_pct != 0) && ($urandom_range(99) < out_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.center_valid = center_valid_o;
      got.isolated     = isolated_o;
      got.center_row   = center_row_o;
      got.center_col   = center_col_o;
      got.island_count = island_count_o;
      got.frame_done   = frame_done_o;
      ledger.check_result(got);
    end
  end

  // watchdog: cycles without any accepted transaction
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // entered and left at a falling edge
  task automatic send_pixel(input bit p);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    pixel_i    = p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ledger.scan_pixel(p);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_run(input int n, input int density);
    repeat (n) send_pixel($urandom_range(99) < density);
  endtask

  // results trail their pixel through the window stage and the result queue; drain, then spare idle cycles
  task automatic settle();
    while (ledger.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    ledger.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic configure(input logic [CfgW-1:0] cols, input logic [CfgW-1:0] rows);
    settle();
    write_reg(RegFrameCols, cols);
    write_reg(RegFrameRows, rows);
  endtask

  function automatic logic [CfgW-1:0] pick_size();
    if ($urandom_range(7) == 0) return CfgW'($urandom_range(2));
    return CfgW'($urandom_range(3, 12));
  endfunction

  initial begin
    int sent;
    int phase;
    int n;
    ledger = new();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // smallest frame: the one interior pixel is isolated since the border reads 0
    configure(3, 3);
    repeat (9) send_pixel(1'b1);
    // undersized registers clamp to 3; abandon the frame midway
    configure(2, 1);
    repeat (4) send_pixel(1'b1);
    settle();
    write_reg(RegFrameRows, 0);
    for (int i = 0; i < 9; i++) send_pixel(i[0]);

    // register values past the limits clamp to the largest frame; partial frames
    configure(2047, 3);
    send_run(40, 20);
    configure(3, 1025);
    send_run(60, 20);

    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      settle();
      in_idle_pct  = (phase == 0 || phase == 2) ? 0 : 32;
      out_idle_pct = (phase == 0) ? 0 : 32;
      if ($urandom_range(4) == 0) begin
        write_reg($urandom_range(1) ? RegFrameRows : RegFrameCols, pick_size());
      end else begin
        write_reg(RegFrameCols, pick_size());
        write_reg(RegFrameRows, pick_size());
      end
      n = (phase == 0) ? 150 : (phase == 2) ? 120 : $urandom_range(10, 160);
      if (phase == 2) hold_left = HoldStretch;
      case ($urandom_range(2))
        0: send_run(n, 10);
        1: send_run(n, 25);
        default: send_run(n, 50);
      endcase
      sent += n;
      phase++;
    end

    while (ledger.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (ledger.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
